/* sv/ffx_pkg.sv */
// ----------------------------------------------------------------------------
// ffx_pkg: shared types, constants and decode helpers
// Character codes, scan phases, the per-item result bundle and the
// percent-decoding steps used by the field extractor.
// ----------------------------------------------------------------------------
package ffx_pkg;

  // Character codes
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  // Key length clamp
  localparam int KEY_MAX_CHARS = 8;

  // Result queue depth between scanner and output serializer
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_TEXT    = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [63:0] KEY_TEXT_RST    = 64'd1684632435;
  localparam logic [3:0]  KEY_LENGTH_RST  = 4'd4;
  localparam logic [7:0]  VALUE_LIMIT_RST = 8'd32;

  // Scan phases
  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // Results caused by one body item: up to three value bytes, then
  // an optional done item
  typedef struct packed {
    logic [1:0]      n_vals;
    logic [2:0][7:0] vals;
    logic            done;
    logic            found;
  } bundle_t;

  // Escape decoder state plus the results gathered so far
  typedef struct packed {
    logic [1:0] pcnt;   // 0 none, 1 '%', 2 '%' and one character
    logic [7:0] hold;   // held character when pcnt is 2
    bundle_t    bun;
  } dec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t   r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      r.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + HEX_ALPHA_BASE;
      r.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + HEX_ALPHA_BASE;
      r.ok = 1'b1;
    end
    r.val = t[3:0];
    return r;
  endfunction

  function automatic dec_t push_byte(dec_t d, logic [7:0] c);
    dec_t r;
    r = d;
    if (d.bun.n_vals != 2'd3) begin
      r.bun.vals[d.bun.n_vals] = c;
      r.bun.n_vals = d.bun.n_vals + 2'd1;
    end
    return r;
  endfunction

  // One character while fewer than two are held
  function automatic dec_t feed_low(dec_t d, logic [7:0] c);
    dec_t r;
    r = d;
    if (d.pcnt == 2'd0) begin
      if (c == CH_PCT) begin
        r.pcnt = 2'd1;
      end else if (c == CH_PLUS) begin
        r = push_byte(r, CH_SPACE);
      end else begin
        r = push_byte(r, c);
      end
    end else begin
      r.hold = c;
      r.pcnt = 2'd2;
    end
    return r;
  endfunction

  function automatic dec_t feed(dec_t d, logic [7:0] c);
    dec_t       r;
    hex_t       hv;
    hex_t       lv;
    logic [7:0] h;
    r  = d;
    h  = d.hold;
    hv = hex_digit(h);
    lv = hex_digit(c);
    if (d.pcnt != 2'd2) begin
      r = feed_low(d, c);
    end else if (hv.ok && lv.ok) begin
      r = push_byte(r, {hv.val, lv.val});
      r.pcnt = 2'd0;
      r.hold = '0;
    end else begin
      // bad escape: literal '%', then re-run the held character and this char
      r = push_byte(r, CH_PCT);
      r.pcnt = 2'd0;
      r.hold = '0;
      r = feed_low(r, h);
      r = feed_low(r, c);
    end
    return r;
  endfunction

  // Value end: resolve a held escape
  function automatic dec_t flush(dec_t d);
    dec_t r;
    r = d;
    if (d.pcnt == 2'd2) begin
      r = push_byte(r, CH_PCT);
      r.pcnt = 2'd0;
      r = feed_low(r, d.hold);
    end
    if (r.pcnt == 2'd1) begin
      r = push_byte(r, CH_PCT);
    end
    r.pcnt = 2'd0;
    r.hold = '0;
    return r;
  endfunction

endpackage

/* sv/ffx_front.sv */
// ----------------------------------------------------------------------------
// ffx_front: body scanner and value decoder
// Holds the configuration, matches the key, percent-decodes the value and
// hands a result bundle to the queue for each body item that yields results.
// ----------------------------------------------------------------------------
module ffx_front
  import ffx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // body items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_body_end,
  // queue side
  input  logic        q_full,
  output logic        q_push,
  output bundle_t     q_data
);

  logic [63:0] key_text_r;
  logic [3:0]  key_length_r;
  logic [7:0]  value_limit_r;

  phase_t      phase_r,  phase_nxt;
  logic [3:0]  kmc_r,    kmc_nxt;
  logic [1:0]  pcnt_r,   pcnt_nxt;
  logic [7:0]  hold_r,   hold_nxt;
  logic [7:0]  taken_r,  taken_nxt;
  logic        found_r,  found_nxt;

  logic        accept;
  logic [3:0]  klen;
  logic        key_done;
  logic [7:0]  key_char;
  logic        hit_eq;
  logic        found_now;

  dec_t        vd;
  dec_t        vd_out;
  logic [7:0]  taken_v;
  logic        val_end;
  bundle_t     bun;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_text_r    <= KEY_TEXT_RST;
      key_length_r  <= KEY_LENGTH_RST;
      value_limit_r <= VALUE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_TEXT:    key_text_r    <= cfg_data;
        CFG_KEY_LENGTH:  key_length_r  <= cfg_data[3:0];
        CFG_VALUE_LIMIT: value_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Key match helpers
  assign klen      = (key_length_r > 4'(KEY_MAX_CHARS)) ? 4'(KEY_MAX_CHARS) : key_length_r;
  assign key_done  = (kmc_r >= klen);
  assign key_char  = key_text_r[{kmc_r[2:0], 3'b000} +: 8];
  assign hit_eq    = (phase_r == PH_MATCH) && key_done && (in_body_byte == CH_EQ);
  assign found_now = found_r || hit_eq;

  // Value path decode
  always_comb begin
    vd        = '0;
    vd.pcnt   = pcnt_r;
    vd.hold   = hold_r;
    taken_v   = taken_r;
    val_end   = 1'b0;
    if (in_body_byte == CH_AMP) begin
      vd      = flush(vd);
      val_end = 1'b1;
    end else if (taken_r < value_limit_r) begin
      vd      = feed(vd, in_body_byte);
      taken_v = taken_r + 8'd1;
      if (taken_v >= value_limit_r) begin
        vd      = flush(vd);
        val_end = 1'b1;
      end
    end else begin
      vd      = flush(vd);
      val_end = 1'b1;
    end
    // body end while still in the value
    vd_out = (in_body_end && !val_end) ? flush(vd) : vd;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    kmc_nxt   = kmc_r;
    pcnt_nxt  = pcnt_r;
    hold_nxt  = hold_r;
    taken_nxt = taken_r;
    found_nxt = found_r;
    unique case (phase_r)
      PH_MATCH: begin
        if (key_done) begin
          if (in_body_byte == CH_EQ) begin
            found_nxt = 1'b1;
            taken_nxt = '0;
            phase_nxt = (value_limit_r == '0) ? PH_DONE : PH_VALUE;
          end else if (in_body_byte == CH_AMP) begin
            kmc_nxt = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else if (in_body_byte == key_char) begin
          kmc_nxt = kmc_r + 4'd1;
        end else if (in_body_byte == CH_AMP) begin
          kmc_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (in_body_byte == CH_AMP) begin
          phase_nxt = PH_MATCH;
          kmc_nxt   = '0;
        end
      end
      PH_VALUE: begin
        pcnt_nxt  = vd.pcnt;
        hold_nxt  = vd.hold;
        taken_nxt = taken_v;
        if (val_end) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
    // body end starts a new body
    if (in_body_end) begin
      phase_nxt = PH_MATCH;
      kmc_nxt   = '0;
      pcnt_nxt  = '0;
      hold_nxt  = '0;
      taken_nxt = '0;
      found_nxt = 1'b0;
    end
  end

  // Result bundle for this item
  always_comb begin
    bun = '0;
    if (phase_r == PH_VALUE) begin
      bun = vd_out.bun;
    end
    bun.done  = in_body_end;
    bun.found = in_body_end && found_now;
  end

  assign q_data = bun;
  assign q_push = accept && ((bun.n_vals != 2'd0) || bun.done);

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MATCH;
      kmc_r   <= '0;
      pcnt_r  <= '0;
      hold_r  <= '0;
      taken_r <= '0;
      found_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kmc_r   <= kmc_nxt;
      pcnt_r  <= pcnt_nxt;
      hold_r  <= hold_nxt;
      taken_r <= taken_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

/* sv/ffx_queue.sv */
// ----------------------------------------------------------------------------
// ffx_queue: result bundle queue
// Small FIFO of result bundles between the scanner and the serializer.
// ----------------------------------------------------------------------------
module ffx_queue
  import ffx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r,  cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[head_r];

  // Pointer and count update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= push_data;
    end
  end

endmodule

/* sv/ffx_back.sv */
// ----------------------------------------------------------------------------
// ffx_back: result serializer
// Takes one bundle at a time from the queue and sends its value bytes and
// done item out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module ffx_back
  import ffx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // queue side
  input  logic       q_empty,
  input  bundle_t    q_data,
  output logic       q_pop,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value_byte,
  output logic       out_done_res,
  output logic       out_found
);

  bundle_t    cur_r,       cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r,       idx_nxt;
  logic [2:0] n_items;
  logic       last_item;
  logic       take;
  logic       load;

  // Item bookkeeping
  assign n_items   = {1'b0, cur_r.n_vals} + {2'b00, cur_r.done};
  assign last_item = (({1'b0, idx_r} + 3'd1) == n_items);
  assign take      = cur_valid_r && !out_stall;
  assign load      = !cur_valid_r || (take && last_item);
  assign q_pop     = load && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_nxt       = q_data;
      cur_valid_nxt = !q_empty;
      idx_nxt       = '0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Output item select
  assign out_valid = cur_valid_r;

  always_comb begin
    out_value_byte = '0;
    if (idx_r < cur_r.n_vals) begin
      case (idx_r)
        2'd0:    out_value_byte = cur_r.vals[0];
        2'd1:    out_value_byte = cur_r.vals[1];
        2'd2:    out_value_byte = cur_r.vals[2];
        default: out_value_byte = '0;
      endcase
    end
  end

  assign out_done_res = cur_r.done && (idx_r == cur_r.n_vals);
  assign out_found    = out_done_res && cur_r.found;

endmodule

/* sv/form_field_extract_decode.sv */
// Result path: an accepted item's first result is written into the bundle queue, then
// loaded into the serializer register, from which it is offered when the serializer is idle.
// Throughput: one body item per cycle unless the queue is full; the serializer sends one
// result per cycle unless stalled; the bundle queue absorbs bursts of multi-result items.
// Reset (synchronous, active low): configuration returns to its defaults, the scanner
// goes to field start and the queue and serializer empty.
// ----------------------------------------------------------------------------
// form_field_extract_decode: form field extractor with percent decoding
// Scanner front end, bundle queue and output serializer.
// ----------------------------------------------------------------------------
module form_field_extract_decode
  import ffx_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // body items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_body_end,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_value_byte,
  output logic        out_done_res,
  output logic        out_found
);

  logic    q_full;
  logic    q_push;
  bundle_t q_wdata;
  logic    q_empty;
  logic    q_pop;
  bundle_t q_rdata;

  // Scanner and decoder
  ffx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_body_byte (in_body_byte),
    .in_body_end  (in_body_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  // Bundle queue
  ffx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Output serializer
  ffx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_byte (out_value_byte),
    .out_done_res   (out_done_res),
    .out_found      (out_found)
  );

endmodule
